@@ design/assert_macros.svh @@
// assert_macros.svh
// Concurrent assertion helpers used by elapsed_time_to_calendar.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/etcal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etcal_pkg
// Constants, types and helper functions of the elapsed time calendar.
// ----------------------------------------------------------------------------
package etcal_pkg;

  localparam int MS_PER_SEC     = 1000;
  localparam int SEC_PER_DAY    = 86400;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_MIN    = 60;
  localparam int HOURS_PER_DAY  = 24;
  localparam int MIN_PER_HOUR   = 60;
  localparam int YEAR_CENT      = 100;
  localparam int MONTH_FEB      = 2;
  localparam int MONTH_DEC      = 12;
  localparam logic [1:0] LEAP_MASK = 2'b11;

  localparam int RATIO_W        = 8;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd1;
  localparam int OFS_W          = 18;

  // Remainder width of the serial divider: holds values below 86400.
  localparam int DIV_W          = 17;
  localparam int CNT_W          = 5;

  // Quotient bits each division produces; the upper dividend bits that are
  // preloaded into the remainder always stay below the divisor.
  localparam int YEAR_STEPS     = 10;
  localparam int MS_STEPS       = 23;
  localparam int DAY_STEPS      = 16;
  localparam int HOUR_STEPS     = 5;
  localparam int MIN_STEPS      = 6;

  typedef enum logic [2:0] {
    DIV_YEAR,
    DIV_MS,
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_op_e;

  typedef struct packed {
    logic    start;
    div_op_e op;
  } div_ctl_t;

  function automatic logic [DIV_W-1:0] div_divisor(div_op_e op);
    logic [DIV_W-1:0] dv;
    unique case (op)
      DIV_YEAR: dv = DIV_W'(YEAR_CENT);
      DIV_MS:   dv = DIV_W'(MS_PER_SEC);
      DIV_DAY:  dv = DIV_W'(SEC_PER_DAY);
      DIV_HOUR: dv = DIV_W'(SEC_PER_HOUR);
      DIV_MIN:  dv = DIV_W'(SEC_PER_MIN);
      default:  dv = DIV_W'(SEC_PER_MIN);
    endcase
    return dv;
  endfunction

  function automatic logic [CNT_W-1:0] div_steps(div_op_e op);
    logic [CNT_W-1:0] n;
    unique case (op)
      DIV_YEAR: n = CNT_W'(YEAR_STEPS);
      DIV_MS:   n = CNT_W'(MS_STEPS);
      DIV_DAY:  n = CNT_W'(DAY_STEPS);
      DIV_HOUR: n = CNT_W'(HOUR_STEPS);
      DIV_MIN:  n = CNT_W'(MIN_STEPS);
      default:  n = CNT_W'(MIN_STEPS);
    endcase
    return n;
  endfunction

  // Days in a month, February without the leap day; bad months give 0.
  function automatic logic [4:0] month_len(logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ design/etcal_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etcal_div
// Bit-serial restoring divider by a selectable constant, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module etcal_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  etcal_pkg::div_ctl_t            ctl_i,
  input  logic [31:0]                    dividend_i,
  output logic                           done_o,
  output logic [31:0]                    quot_o,
  output logic [etcal_pkg::DIV_W-1:0]    rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [etcal_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  etcal_pkg::div_op_e            op_q, op_d;
  logic [etcal_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [31:0]                   sh_q, sh_d;

  logic [etcal_pkg::DIV_W-1:0]   rem_init;
  logic [31:0]                   sh_init;
  logic [etcal_pkg::DIV_W:0]     part;
  logic [etcal_pkg::DIV_W:0]     dsr;
  logic [etcal_pkg::DIV_W:0]     diff;
  logic                          take;
  logic [etcal_pkg::CNT_W-1:0]   last;

  // Upper dividend bits go straight into the remainder, the rest is shifted
  // in one bit a cycle while quotient bits fill the low end.
  always_comb begin
    unique case (ctl_i.op)
      etcal_pkg::DIV_YEAR: begin
        rem_init = etcal_pkg::DIV_W'(dividend_i >> etcal_pkg::YEAR_STEPS);
        sh_init  = dividend_i << (32 - etcal_pkg::YEAR_STEPS);
      end
      etcal_pkg::DIV_MS: begin
        rem_init = etcal_pkg::DIV_W'(dividend_i >> etcal_pkg::MS_STEPS);
        sh_init  = dividend_i << (32 - etcal_pkg::MS_STEPS);
      end
      etcal_pkg::DIV_DAY: begin
        rem_init = etcal_pkg::DIV_W'(dividend_i >> etcal_pkg::DAY_STEPS);
        sh_init  = dividend_i << (32 - etcal_pkg::DAY_STEPS);
      end
      etcal_pkg::DIV_HOUR: begin
        rem_init = etcal_pkg::DIV_W'(dividend_i >> etcal_pkg::HOUR_STEPS);
        sh_init  = dividend_i << (32 - etcal_pkg::HOUR_STEPS);
      end
      etcal_pkg::DIV_MIN: begin
        rem_init = etcal_pkg::DIV_W'(dividend_i >> etcal_pkg::MIN_STEPS);
        sh_init  = dividend_i << (32 - etcal_pkg::MIN_STEPS);
      end
      default: begin
        rem_init = '0;
        sh_init  = '0;
      end
    endcase
  end

  always_comb begin
    last = etcal_pkg::div_steps(op_q) - etcal_pkg::CNT_W'(1);
    part = {rem_q, sh_q[31]};
    dsr  = {1'b0, etcal_pkg::div_divisor(op_q)};
    take = (part >= dsr);
    diff = part - dsr;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    sh_d   = sh_q;

    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = ctl_i.op;
      rem_d  = rem_init;
      sh_d   = sh_init;
    end else if (busy_q) begin
      rem_d = take ? diff[etcal_pkg::DIV_W-1:0] : part[etcal_pkg::DIV_W-1:0];
      sh_d  = {sh_q[30:0], take};
      cnt_d = cnt_q + etcal_pkg::CNT_W'(1);
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= etcal_pkg::DIV_MIN;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule

@@ design/etcal_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etcal_mul
// Serial shift-add multiplier, one ratio bit per cycle, with a preloaded
// addend. Product wraps at 32 bits.
// ----------------------------------------------------------------------------
module etcal_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [31:0]                    mcand_i,
  input  logic [etcal_pkg::RATIO_W-1:0]  mplier_i,
  input  logic [31:0]                    addend_i,
  output logic                           done_o,
  output logic [31:0]                    prod_o
);

  localparam int MCntW = $clog2(etcal_pkg::RATIO_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [MCntW-1:0]              cnt_q, cnt_d;
  logic [31:0]                   acc_q, acc_d;
  logic [31:0]                   mcand_q, mcand_d;
  logic [etcal_pkg::RATIO_W-1:0] mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;

    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = addend_i;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[30:0], 1'b0};
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + MCntW'(1);
      if (cnt_q == MCntW'(etcal_pkg::RATIO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ design/elapsed_time_to_calendar.sv @@
// ----------------------------------------------------------------------------
// elapsed_time_to_calendar: one word at a time; a load word goes through S_LOAD to the output registers.
// An update word runs S_YEAR (February base month only), S_MS, S_MUL, S_DAY, S_HOUR, S_MIN, S_CAL,
// using the bit-serial divider (one quotient bit per cycle) and the serial ratio multiplier.
// Reset: ratio = 1, base stamp and base date/time = 0; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module elapsed_time_to_calendar (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [etcal_pkg::RATIO_W-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [31:0]                    time_ms_i,
  input  logic [15:0]                    year_in_i,
  input  logic [3:0]                     month_in_i,
  input  logic [4:0]                     day_in_i,
  input  logic [4:0]                     hour_in_i,
  input  logic [5:0]                     minute_in_i,
  input  logic [5:0]                     second_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    year_out_o,
  output logic [3:0]                     month_out_o,
  output logic [7:0]                     day_out_o,
  output logic [4:0]                     hour_out_o,
  output logic [5:0]                     minute_out_o,
  output logic [5:0]                     second_out_o,
  output logic                           rolled_over_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_YEAR = 4'd1;
  localparam logic [3:0] S_MS   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DAY  = 4'd4;
  localparam logic [3:0] S_HOUR = 4'd5;
  localparam logic [3:0] S_MIN  = 4'd6;
  localparam logic [3:0] S_CAL  = 4'd7;
  localparam logic [3:0] S_LOAD = 4'd8;

  logic [3:0]                    state_q, state_d;
  logic                          launch_q, launch_d;
  logic [etcal_pkg::RATIO_W-1:0] ratio_q;

  logic [31:0] stamp_q, stamp_d;
  logic [15:0] byear_q, byear_d;
  logic [3:0]  bmonth_q, bmonth_d;
  logic [7:0]  bday_q, bday_d;
  logic [4:0]  bhour_q, bhour_d;
  logic [5:0]  bmin_q, bmin_d;
  logic [5:0]  bsec_q, bsec_d;

  logic [31:0] now_q, now_d;
  logic        leap_q, leap_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hh_q, hh_d;
  logic [5:0]  mm_q, mm_d;
  logic [5:0]  ss_q, ss_d;

  logic        oval_q, oval_d;
  logic [15:0] oyear_q, oyear_d;
  logic [3:0]  omonth_q, omonth_d;
  logic [7:0]  oday_q, oday_d;
  logic [4:0]  ohour_q, ohour_d;
  logic [5:0]  omin_q, omin_d;
  logic [5:0]  osec_q, osec_d;
  logic        oroll_q, oroll_d;

  etcal_pkg::div_ctl_t           div_ctl;
  logic [31:0]                   div_dividend;
  logic                          div_done;
  logic [31:0]                   div_quot;
  logic [etcal_pkg::DIV_W-1:0]   div_rem;
  logic                          mul_start;
  logic                          mul_done;
  logic [31:0]                   mul_prod;
  logic [etcal_pkg::OFS_W-1:0]   tod_ofs;

  logic        accept;
  logic        out_free;
  logic [4:0]  mlen;
  logic [16:0] day_sum;
  logic        roll;
  logic [3:0]  month_inc;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !oval_q || !out_stall_i;

  // Base time of day in seconds, preloaded into the multiplier accumulator.
  assign tod_ofs = etcal_pkg::OFS_W'(bhour_q) * etcal_pkg::OFS_W'(etcal_pkg::SEC_PER_HOUR)
                 + etcal_pkg::OFS_W'(bmin_q) * etcal_pkg::OFS_W'(etcal_pkg::SEC_PER_MIN)
                 + etcal_pkg::OFS_W'(bsec_q);

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.op    = etcal_pkg::DIV_MIN;
    div_dividend  = 32'(div_rem);
    unique case (state_q)
      S_YEAR: begin
        div_ctl.op   = etcal_pkg::DIV_YEAR;
        div_dividend = 32'(byear_q);
      end
      S_MS: begin
        div_ctl.op   = etcal_pkg::DIV_MS;
        div_dividend = now_q - stamp_q;
      end
      S_DAY: begin
        div_ctl.op   = etcal_pkg::DIV_DAY;
        div_dividend = mul_prod;
      end
      S_HOUR:  div_ctl.op = etcal_pkg::DIV_HOUR;
      S_MIN:   div_ctl.op = etcal_pkg::DIV_MIN;
      default: div_ctl.op = etcal_pkg::DIV_MIN;
    endcase
    div_ctl.start = launch_q && (state_q == S_YEAR || state_q == S_MS ||
                                 state_q == S_DAY || state_q == S_HOUR ||
                                 state_q == S_MIN);
  end

  assign mul_start = launch_q && (state_q == S_MUL);

  etcal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  etcal_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (div_quot),
    .mplier_i (ratio_q),
    .addend_i (32'(tod_ofs)),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Calendar step: month length with the leap day, day carry into the month.
  always_comb begin
    mlen = etcal_pkg::month_len(bmonth_q)
         + 5'((bmonth_q == 4'(etcal_pkg::MONTH_FEB)) && leap_q);
    day_sum   = 17'(bday_q) + 17'(days_q);
    roll      = day_sum > 17'(mlen);
    month_inc = bmonth_q + 4'd1;
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    stamp_d  = stamp_q;
    byear_d  = byear_q;
    bmonth_d = bmonth_q;
    bday_d   = bday_q;
    bhour_d  = bhour_q;
    bmin_d   = bmin_q;
    bsec_d   = bsec_q;
    now_d    = now_q;
    leap_d   = leap_q;
    days_d   = days_q;
    hh_d     = hh_q;
    mm_d     = mm_q;
    ss_d     = ss_q;
    oyear_d  = oyear_q;
    omonth_d = omonth_q;
    oday_d   = oday_q;
    ohour_d  = ohour_q;
    omin_d   = omin_q;
    osec_d   = osec_q;
    oroll_d  = oroll_q;
    oval_d   = oval_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i) begin
            now_d    = time_ms_i;
            leap_d   = 1'b0;
            launch_d = 1'b1;
            state_d  = (bmonth_q == 4'(etcal_pkg::MONTH_FEB)) ? S_YEAR : S_MS;
          end else begin
            stamp_d  = time_ms_i;
            byear_d  = year_in_i;
            bmonth_d = month_in_i;
            bday_d   = 8'(day_in_i);
            bhour_d  = hour_in_i;
            bmin_d   = minute_in_i;
            bsec_d   = second_in_i;
            state_d  = S_LOAD;
          end
        end
      end
      S_YEAR: begin
        if (div_done) begin
          // remainder by 100 and quotient mod 4 give the century rules
          leap_d = (((byear_q[1:0] & etcal_pkg::LEAP_MASK) == 2'b00) && (div_rem != '0))
                || ((div_rem == '0) && (div_quot[1:0] == 2'b00));
          launch_d = 1'b1;
          state_d  = S_MS;
        end
      end
      S_MS: begin
        if (div_done) begin
          launch_d = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          launch_d = 1'b1;
          state_d  = S_DAY;
        end
      end
      S_DAY: begin
        if (div_done) begin
          days_d   = div_quot[15:0];
          launch_d = 1'b1;
          state_d  = S_HOUR;
        end
      end
      S_HOUR: begin
        if (div_done) begin
          hh_d     = div_quot[4:0];
          launch_d = 1'b1;
          state_d  = S_MIN;
        end
      end
      S_MIN: begin
        if (div_done) begin
          mm_d    = div_quot[5:0];
          ss_d    = div_rem[5:0];
          state_d = S_CAL;
        end
      end
      S_CAL: begin
        if (out_free) begin
          oval_d  = 1'b1;
          ohour_d = hh_q;
          omin_d  = mm_q;
          osec_d  = ss_q;
          oroll_d = roll;
          if (roll) begin
            oday_d = 8'(day_sum - 17'(mlen));
            if (bmonth_q == 4'(etcal_pkg::MONTH_DEC)) begin
              oyear_d  = byear_q + 16'd1;
              omonth_d = 4'd1;
            end else begin
              oyear_d  = byear_q;
              omonth_d = month_inc;
            end
            stamp_d  = now_q;
            byear_d  = oyear_d;
            bmonth_d = omonth_d;
            bday_d   = oday_d;
            bhour_d  = hh_q;
            bmin_d   = mm_q;
            bsec_d   = ss_q;
          end else begin
            oday_d   = day_sum[7:0];
            oyear_d  = byear_q;
            omonth_d = bmonth_q;
          end
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          oval_d   = 1'b1;
          oyear_d  = byear_q;
          omonth_d = bmonth_q;
          oday_d   = bday_q;
          ohour_d  = bhour_q;
          omin_d   = bmin_q;
          osec_d   = bsec_q;
          oroll_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      oval_q   <= 1'b0;
      ratio_q  <= etcal_pkg::RATIO_RESET;
      stamp_q  <= '0;
      byear_q  <= '0;
      bmonth_q <= '0;
      bday_q   <= '0;
      bhour_q  <= '0;
      bmin_q   <= '0;
      bsec_q   <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      oval_q   <= oval_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
      stamp_q  <= stamp_d;
      byear_q  <= byear_d;
      bmonth_q <= bmonth_d;
      bday_q   <= bday_d;
      bhour_q  <= bhour_d;
      bmin_q   <= bmin_d;
      bsec_q   <= bsec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    leap_q   <= leap_d;
    days_q   <= days_d;
    hh_q     <= hh_d;
    mm_q     <= mm_d;
    ss_q     <= ss_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
    ohour_q  <= ohour_d;
    omin_q   <= omin_d;
    osec_q   <= osec_d;
    oroll_q  <= oroll_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = oval_q;
  assign year_out_o    = oyear_q;
  assign month_out_o   = omonth_q;
  assign day_out_o     = oday_q;
  assign hour_out_o    = ohour_q;
  assign minute_out_o  = omin_q;
  assign second_out_o  = osec_q;
  assign rolled_over_o = oroll_q;

  `ASSERT_IMPL(a_div_done_state, clk_i, rst_ni, div_done, (state_q == S_YEAR || state_q == S_MS || state_q == S_DAY || state_q == S_HOUR || state_q == S_MIN), "divider done outside a divide step")
  `ASSERT_IMPL(a_mul_done_state, clk_i, rst_ni, mul_done, (state_q == S_MUL), "multiplier done outside the multiply step")
  `ASSERT_IMPL(a_roll_tod_range, clk_i, rst_ni, (out_valid_o && rolled_over_o), (hour_out_o < etcal_pkg::HOURS_PER_DAY && minute_out_o < etcal_pkg::MIN_PER_HOUR && second_out_o < etcal_pkg::SEC_PER_MIN), "rollover word with time of day out of range")
  `ASSERT_NEXT(a_cal_roll_base, clk_i, rst_ni, (state_q == S_CAL && out_free && roll), (stamp_q == $past(now_q) && bday_q == oday_q), "rollover did not reload the base")

endmodule

@@ sim/elapsed_time_to_calendar_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elapsed_time_to_calendar_tb
// Self-checking bench for the elapsed time calendar. A directed table covers
// the leap rule, month and year rollover, bad months, stamp wrap and field
// extremes; random load/update sequences then run under several ratios and
// handshake idling patterns. Every result is checked against a local model or a table entry.
// ----------------------------------------------------------------------------
module elapsed_time_to_calendar_tb;
  import etcal_pkg::*;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 116;
  localparam int NUM_PHASES    = 8;
  localparam int RATIO_RANDOM  = -1;

  localparam int PHASE_RATIO [NUM_PHASES] = '{255, 0, 1, RATIO_RANDOM, 255, 60, RATIO_RANDOM, 255};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 64, 0, 14, 64, 0, 0, 14};
  localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 64, 14, 0, 64, 0, 14};

  localparam logic [4:0] DAYS_IN_MONTH [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef struct packed {
    logic        mode;
    logic [31:0] ms;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_word_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [7:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        rolled;
  } date_time_t;

  typedef struct {
    stamp_word_t word;
    bit          typed;
    date_time_t  want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               mode_i = 1'b0;
  logic [31:0]        time_ms_i = '0;
  logic [15:0]        year_in_i = '0;
  logic [3:0]         month_in_i = '0;
  logic [4:0]         day_in_i = '0;
  logic [4:0]         hour_in_i = '0;
  logic [5:0]         minute_in_i = '0;
  logic [5:0]         second_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        year_out_o;
  logic [3:0]         month_out_o;
  logic [7:0]         day_out_o;
  logic [4:0]         hour_out_o;
  logic [5:0]         minute_out_o;
  logic [5:0]         second_out_o;
  logic               rolled_over_o;

  // model state: ratio register and stored base
  logic [RATIO_W-1:0] game_ratio = RATIO_RESET;
  logic [31:0]        base_ms = '0;
  logic [15:0]        base_yr = '0;
  logic [3:0]         base_mon = '0;
  logic [7:0]         base_day = '0;
  logic [4:0]         base_hr = '0;
  logic [5:0]         base_min = '0;
  logic [5:0]         base_sec = '0;

  date_time_t pending_dates[$];
  dir_row_t   dir_rows[$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  elapsed_time_to_calendar u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .time_ms_i    (time_ms_i),
    .year_in_i    (year_in_i),
    .month_in_i   (month_in_i),
    .day_in_i     (day_in_i),
    .hour_in_i    (hour_in_i),
    .minute_in_i  (minute_in_i),
    .second_in_i  (second_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .year_out_o   (year_out_o),
    .month_out_o  (month_out_o),
    .day_out_o    (day_out_o),
    .hour_out_o   (hour_out_o),
    .minute_out_o (minute_out_o),
    .second_out_o (second_out_o),
    .rolled_over_o(rolled_over_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit is_leap_year(logic [15:0] y);
    return ((y[1:0] == 2'b00) && (y % 16'd100 != 16'd0)) || (y % 16'd400 == 16'd0);
  endfunction

  // Applies one word to the model base and returns the calendar it yields.
  function automatic date_time_t advance_calendar(stamp_word_t w);
    date_time_t  r;
    logic [31:0] secs;
    logic [31:0] days;
    logic [31:0] hrs;
    logic [31:0] mins;
    logic [31:0] day_sum;
    logic [31:0] mlen;
    logic [3:0]  next_month;
    r = '0;
    if (w.mode == MODE_LOAD) begin
      base_ms  = w.ms;
      base_yr  = w.year;
      base_mon = w.month;
      base_day = 8'(w.day);
      base_hr  = w.hour;
      base_min = w.minute;
      base_sec = w.second;
      r.year   = base_yr;
      r.month  = base_mon;
      r.day    = base_day;
      r.hour   = base_hr;
      r.minute = base_min;
      r.second = base_sec;
      return r;
    end
    secs = ((w.ms - base_ms) / 32'(MS_PER_SEC)) * 32'(game_ratio);
    secs = secs + 32'(base_sec) + 32'(base_min) * 32'(SEC_PER_MIN)
         + 32'(base_hr) * 32'(SEC_PER_HOUR);
    days = secs / 32'(SEC_PER_DAY);
    secs = secs - days * 32'(SEC_PER_DAY);
    hrs  = secs / 32'(SEC_PER_HOUR);
    secs = secs - hrs * 32'(SEC_PER_HOUR);
    mins = secs / 32'(SEC_PER_MIN);
    secs = secs - mins * 32'(SEC_PER_MIN);
    mlen = 32'(DAYS_IN_MONTH[base_mon]);
    if (base_mon == 4'd2 && is_leap_year(base_yr)) mlen = mlen + 32'd1;
    day_sum  = 32'(base_day) + days;
    r.hour   = hrs[4:0];
    r.minute = mins[5:0];
    r.second = secs[5:0];
    if (day_sum > mlen) begin
      next_month = base_mon + 4'd1;
      r.day = 8'(day_sum - mlen);
      if (next_month == 4'd13) begin
        r.year  = base_yr + 16'd1;
        r.month = 4'd1;
      end else begin
        r.year  = base_yr;
        r.month = next_month;
      end
      r.rolled = 1'b1;
      // base restarts at this word's stamp; sub-second part is dropped
      base_ms  = w.ms;
      base_yr  = r.year;
      base_mon = r.month;
      base_day = r.day;
      base_hr  = r.hour;
      base_min = r.minute;
      base_sec = r.second;
    end else begin
      r.day   = day_sum[7:0];
      r.month = base_mon;
      r.year  = base_yr;
    end
    return r;
  endfunction

  function automatic stamp_word_t load_word(logic [31:0] ms, logic [15:0] y, logic [3:0] mo,
                                            logic [4:0] d, logic [4:0] h, logic [5:0] mi,
                                            logic [5:0] s);
    return '{MODE_LOAD, ms, y, mo, d, h, mi, s};
  endfunction

  function automatic stamp_word_t update_word(logic [31:0] ms);
    return '{MODE_UPDATE, ms, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
  endfunction

  function automatic date_time_t date_of(logic [15:0] y, logic [3:0] mo, logic [7:0] d,
                                         logic [4:0] h, logic [5:0] mi, logic [5:0] s,
                                         logic r);
    return '{y, mo, d, h, mi, s, r};
  endfunction

  function automatic void add_row(stamp_word_t w, bit typed, date_time_t want);
    dir_rows.push_back('{w, typed, want});
  endfunction

  function automatic stamp_word_t random_word();
    stamp_word_t w;
    w.mode   = 1'($urandom);
    w.ms     = $urandom;
    w.year   = 16'($urandom);
    w.month  = 4'($urandom);
    w.day    = 5'($urandom);
    w.hour   = 5'($urandom);
    w.minute = 6'($urandom);
    w.second = 6'($urandom);
    return w;
  endfunction

  function automatic void report_miss(string what, date_time_t want, date_time_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s exp %0d/%0d/%0d %0d:%0d:%0d r%0d got %0d/%0d/%0d %0d:%0d:%0d r%0d",
               $time, what, want.year, want.month, want.day, want.hour, want.minute,
               want.second, want.rolled, got.year, got.month, got.day, got.hour, got.minute,
               got.second, got.rolled);
  endfunction

  // Offers one word, waits for accept, then queues its expected date.
  task automatic send_word(stamp_word_t w, bit typed, date_time_t want);
    date_time_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= w.mode;
    time_ms_i   <= w.ms;
    year_in_i   <= w.year;
    month_in_i  <= w.month;
    day_in_i    <= w.day;
    hour_in_i   <= w.hour;
    minute_in_i <= w.minute;
    second_in_i <= w.second;
    do @(posedge clk_i); while (in_stall_o);
    pred = advance_calendar(w);
    pending_dates.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    game_ratio = v;
  endtask

  // receiver: random stall, or one long hold-off once requested
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    date_time_t got;
    date_time_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{year_out_o, month_out_o, day_out_o, hour_out_o, minute_out_o, second_out_o,
              rolled_over_o};
      if (pending_dates.size() == 0) begin
        report_miss("unexpected word", '0, got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) report_miss("wrong word", want, got);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("elapsed_time_to_calendar: mismatch");
    $finish;
  end

  initial begin
    stamp_word_t w;
    logic [31:0] last_ms;
    logic [31:0] delta;
    logic [31:0] day_ms;
    int          seq_left;
    int          pick;

    // ratio stays at its reset value of 1 through this table
    add_row(update_word(32'd5999), 1'b1, date_of(16'd0, 4'd0, 8'd0, 5'd0, 6'd0, 6'd5, 1'b0));
    add_row(load_word(32'd1000, 16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59), 1'b1,
            date_of(16'd2024, 4'd2, 8'd28, 5'd23, 6'd59, 6'd59, 1'b0));
    add_row(update_word(32'd2000), 1'b0, '0);                  // leap day, no rollover
    add_row(update_word(32'd172_801_000), 1'b0, '0);           // past leap Feb
    add_row(load_word(32'd0, 16'd2023, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0), 1'b1,
            date_of(16'd2023, 4'd2, 8'd28, 5'd0, 6'd0, 6'd0, 1'b0));
    add_row(update_word(32'd86_400_000), 1'b0, '0);
    add_row(load_word(32'd0, 16'd1900, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0), 1'b1,
            date_of(16'd1900, 4'd2, 8'd28, 5'd0, 6'd0, 6'd0, 1'b0));
    add_row(update_word(32'd86_400_000), 1'b0, '0);            // century, not leap
    add_row(load_word(32'd0, 16'd2000, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0), 1'b1,
            date_of(16'd2000, 4'd2, 8'd28, 5'd0, 6'd0, 6'd0, 1'b0));
    add_row(update_word(32'd86_400_000), 1'b0, '0);            // 400-year leap
    add_row(load_word(32'd0, 16'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59), 1'b1,
            date_of(16'd2023, 4'd12, 8'd31, 5'd23, 6'd59, 6'd59, 1'b0));
    add_row(update_word(32'd1000), 1'b1, date_of(16'd2024, 4'd1, 8'd1, 5'd0, 6'd0, 6'd0, 1'b1));
    add_row(load_word(32'd0, 16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59), 1'b1,
            date_of(16'hFFFF, 4'd12, 8'd31, 5'd23, 6'd59, 6'd59, 1'b0));
    add_row(update_word(32'd1000), 1'b1, date_of(16'd0, 4'd1, 8'd1, 5'd0, 6'd0, 6'd0, 1'b1));
    add_row(load_word(32'hFFFF_FFFF, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0), 1'b1, '0);
    add_row(update_word(32'd999), 1'b0, '0);                   // stamp wraps
    add_row(load_word(32'd0, 16'hFFFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63), 1'b1,
            date_of(16'hFFFF, 4'd15, 8'd31, 5'd31, 6'd63, 6'd63, 1'b0));
    add_row(update_word(32'd0), 1'b0, '0);                     // month 15 wraps to 0
    add_row(update_word(32'd0), 1'b0, '0);                     // month 0 has no length
    add_row(load_word(32'd500, 16'd2024, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0), 1'b1,
            date_of(16'd2024, 4'd13, 8'd1, 5'd0, 6'd0, 6'd0, 1'b0));
    add_row(update_word(32'd1499), 1'b0, '0);                  // under a second
    add_row(load_word(32'd0, 16'd2023, 4'd4, 5'd30, 5'd12, 6'd0, 6'd0), 1'b1,
            date_of(16'd2023, 4'd4, 8'd30, 5'd12, 6'd0, 6'd0, 1'b0));
    add_row(update_word(32'd43_199_999), 1'b0, '0);            // last second of the month
    add_row(update_word(32'hFFFF_FFFF), 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (PHASE_RATIO[p] == RATIO_RANDOM) write_ratio(RATIO_W'($urandom_range(2, 254)));
      else write_ratio(RATIO_W'(PHASE_RATIO[p]));
      send_idle_pct = PHASE_IDLE[p];
      stall_pct     = PHASE_STALL[p];
      day_ms   = 32'd86_400_000 / ((game_ratio == '0) ? 32'd1 : 32'(game_ratio));
      last_ms  = $urandom;
      seq_left = 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // long hold-off while words keep coming, so the block backs up
        if (p == 0 && k == 30) hold_req <= 1'b1;
        w = random_word();
        if (seq_left == 0) begin
          seq_left = $urandom_range(1, 8);
          if ($urandom_range(99) >= 10) begin
            w.mode = MODE_LOAD;
            if ($urandom_range(99) < 80) begin
              w.month  = 4'($urandom_range(1, 12));
              w.day    = 5'($urandom_range(1, 31));
              w.hour   = 5'($urandom_range(0, 23));
              w.minute = 6'($urandom_range(0, 59));
              w.second = 6'($urandom_range(0, 59));
            end
          end
        end else begin
          seq_left--;
          pick = $urandom_range(99);
          if (pick < 35) delta = $urandom_range(0, 120_000);
          else if (pick < 80)
            delta = $urandom_range(0, 40) * day_ms + $urandom_range(0, day_ms - 1);
          else if (pick < 93) delta = $urandom_range(0, 3 * day_ms);
          else delta = $urandom;
          w.mode = MODE_UPDATE;
          w.ms   = last_ms + delta;
        end
        last_ms = w.ms;
        send_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    if (err_cnt == 0) $display("elapsed_time_to_calendar: match");
    else $display("elapsed_time_to_calendar: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/etcal_pkg.sv
design/etcal_div.sv
design/etcal_mul.sv
design/elapsed_time_to_calendar.sv
sim/elapsed_time_to_calendar_tb.sv
